FILE: hdl/kei_pkg.sv
`timescale 1ns / 1ps

package kei_pkg;

   // Field widths
   localparam int TIME_BITS      = 32;
   localparam int LEVEL_BITS     = 16;
   localparam int COUNT_BITS     = 5;
   localparam int ENTRY_IDX_BITS = 4;
   localparam int DEF_MAX_KEYS   = 16;
   localparam int INDEX_ARG_BITS = 8;

   // Multiply/divide datapath widths
   localparam int PROD_BITS  = TIME_BITS + LEVEL_BITS;
   localparam int QLIM_BITS  = 35;             // quotients above 2**34 saturate
   localparam int SUM_BITS   = QLIM_BITS + 1;

   // Default keyframe table
   localparam logic [TIME_BITS-1:0]  KEY1_TIME_RESET  = TIME_BITS'(500);
   localparam logic [TIME_BITS-1:0]  KEY2_TIME_RESET  = TIME_BITS'(1000);
   localparam logic [LEVEL_BITS-1:0] KEY1_LEVEL_RESET = LEVEL_BITS'(255);
   localparam logic [COUNT_BITS-1:0] KEY_COUNT_RESET  = COUNT_BITS'(3);

   // Saturation limits
   localparam logic signed [LEVEL_BITS-1:0] LVL_MAX = {1'b0, {(LEVEL_BITS-1){1'b1}}};
   localparam logic signed [LEVEL_BITS-1:0] LVL_MIN = {1'b1, {(LEVEL_BITS-1){1'b0}}};

   // Configuration port
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = COUNT_BITS;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_LOOP_ENABLE = 1'b0,
      CSR_KEY_COUNT   = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      FUNC_TICK  = 2'd0,
      FUNC_START = 2'd1,
      FUNC_WRITE = 2'd2
   } func_type;

   typedef struct packed {
      logic [1:0]                    func;
      logic [TIME_BITS-1:0]          now;
      logic [ENTRY_IDX_BITS-1:0]     entry_index;
      logic [TIME_BITS-1:0]          entry_time;
      logic signed [LEVEL_BITS-1:0]  entry_value;
   } req_type;

   typedef struct packed {
      logic signed [LEVEL_BITS-1:0]  level;
      logic                          active;
   } rsp_type;

   typedef struct packed {
      logic                          en;
      logic [TIME_BITS-1:0]          key_time;
      logic signed [LEVEL_BITS-1:0]  key_level;
   } key_wr_type;

   typedef struct packed {
      logic                   start;
      logic [TIME_BITS-1:0]   a;
      logic [LEVEL_BITS-1:0]  b;
      logic [TIME_BITS-1:0]   c;
   } md_req_type;

   typedef struct packed {
      logic                   done;
      logic                   inexact;
      logic [PROD_BITS-1:0]   quo;
   } md_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SPAN_LAST,
      ST_SPAN_FIRST,
      ST_SPAN_SET,
      ST_END_CMP,
      ST_END_READ,
      ST_END_SET,
      ST_SRCH_READ,
      ST_SRCH_CHK,
      ST_SEG_READ,
      ST_SEG_CALC,
      ST_MUL_START,
      ST_DIV_WAIT,
      ST_SUM,
      ST_SAT
   } kei_state_type;

   // Default time of a table slot that has not been written
   function automatic logic [TIME_BITS-1:0] key_time_reset(
      input logic [INDEX_ARG_BITS-1:0] idx);
      logic [TIME_BITS-1:0] t;
      t = '0;
      if (idx == INDEX_ARG_BITS'(1)) begin
         t = KEY1_TIME_RESET;
      end else if (idx == INDEX_ARG_BITS'(2)) begin
         t = KEY2_TIME_RESET;
      end
      return t;
   endfunction

   // Default level of a table slot that has not been written
   function automatic logic [LEVEL_BITS-1:0] key_level_reset(
      input logic [INDEX_ARG_BITS-1:0] idx);
      logic [LEVEL_BITS-1:0] v;
      v = '0;
      if (idx == INDEX_ARG_BITS'(1)) begin
         v = KEY1_LEVEL_RESET;
      end
      return v;
   endfunction

endpackage

FILE: hdl/kei_key_ram.sv
`timescale 1ns / 1ps

module kei_key_ram #(
   parameter int MAX_KEYS = kei_pkg::DEF_MAX_KEYS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  kei_pkg::key_wr_type                   wr,
   input  logic [$clog2(MAX_KEYS)-1:0]           wr_addr,
   input  logic [$clog2(MAX_KEYS)-1:0]           rd_addr,
   output logic [kei_pkg::TIME_BITS-1:0]         rd_time,
   output logic signed [kei_pkg::LEVEL_BITS-1:0] rd_level
);
   import kei_pkg::*;

   logic [TIME_BITS-1:0]          time_mem [MAX_KEYS];
   logic signed [LEVEL_BITS-1:0]  level_mem [MAX_KEYS];
   logic [MAX_KEYS-1:0]           valid_ff;
   logic [TIME_BITS-1:0]          rd_time_ff;
   logic signed [LEVEL_BITS-1:0]  rd_level_ff;

   // Track written slots; unwritten slots read as the default table
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // Write port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         time_mem[wr_addr]  <= wr.key_time;
         level_mem[wr_addr] <= wr.key_level;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (valid_ff[rd_addr]) begin
         rd_time_ff  <= time_mem[rd_addr];
         rd_level_ff <= level_mem[rd_addr];
      end else begin
         rd_time_ff  <= key_time_reset(INDEX_ARG_BITS'(rd_addr));
         rd_level_ff <= key_level_reset(INDEX_ARG_BITS'(rd_addr));
      end
   end

   assign rd_time  = rd_time_ff;
   assign rd_level = rd_level_ff;

endmodule

FILE: hdl/kei_muldiv.sv
`timescale 1ns / 1ps

module kei_muldiv (
   input  logic                clock,
   input  logic                reset,
   input  kei_pkg::md_req_type req,
   output kei_pkg::md_rsp_type rsp
);
   import kei_pkg::*;

   localparam int CNT_BITS = $clog2(PROD_BITS);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [PROD_BITS-1:0]  prod_ff, prod_in;
   logic [PROD_BITS-1:0]  quo_ff, quo_in;
   logic [TIME_BITS-1:0]  rem_ff, rem_in;
   logic [TIME_BITS-1:0]  div_ff, div_in;
   logic [TIME_BITS:0]    shifted;
   logic [TIME_BITS:0]    diff;
   logic                  fits;

   // One restoring divide step: bring in the next product bit, subtract if it fits
   assign shifted = {rem_ff, prod_ff[PROD_BITS-1]};
   assign diff    = shifted - {1'b0, div_ff};
   assign fits    = shifted >= {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      prod_in = prod_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (req.start) begin
         // Load the product and start the divide
         busy_in = 1'b1;
         cnt_in  = CNT_BITS'(PROD_BITS - 1);
         prod_in = PROD_BITS'(req.a) * PROD_BITS'(req.b);
         quo_in  = '0;
         rem_in  = '0;
         div_in  = req.c;
      end else if (busy_ff) begin
         // Advance one quotient bit
         prod_in = {prod_ff[PROD_BITS-2:0], 1'b0};
         quo_in  = {quo_ff[PROD_BITS-2:0], fits};
         rem_in  = fits ? diff[TIME_BITS-1:0] : shifted[TIME_BITS-1:0];
         cnt_in  = cnt_ff - CNT_BITS'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      prod_ff <= prod_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
   end

   assign rsp.done    = done_ff;
   assign rsp.inexact = (rem_ff != '0);
   assign rsp.quo     = quo_ff;

endmodule

FILE: hdl/keyframe_envelope_interpolator.sv
`timescale 1ns / 1ps

// Sequencing: write, unused and idle-tick transactions answer in the cycle after acceptance;
// start runs SPAN_LAST, SPAN_FIRST, SPAN_SET and an end-of-span tick END_CMP, END_READ,
// END_SET; an interpolating tick probes k segments (k = 1 to the clamped keyframe count
// minus 1), then divides the 48-bit product one bit per cycle; a zero-length segment skips
// the divide. One transaction at a time: busy high until the result issues; no result stall.
// Reset (synchronous): run stopped, loop_enable 0 / keyframe_count 3, default table readable.
module keyframe_envelope_interpolator #(
   parameter int MAX_KEYS = kei_pkg::DEF_MAX_KEYS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  kei_pkg::req_type                      req_data,
   output logic                                  rsp_strobe,
   output kei_pkg::rsp_type                      rsp_data,
   input  logic                                  csr_we,
   input  logic [kei_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [kei_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);
   import kei_pkg::*;

   localparam int IDX_BITS = $clog2(MAX_KEYS);
   localparam int NW = (IDX_BITS + 1 > COUNT_BITS) ? IDX_BITS + 1 : COUNT_BITS;
   localparam logic signed [SUM_BITS-1:0] SUM_LMAX = SUM_BITS'((2 ** (LEVEL_BITS - 1)) - 1);
   localparam logic signed [SUM_BITS-1:0] SUM_LMIN = SUM_BITS'(-(2 ** (LEVEL_BITS - 1)));

   kei_state_type                 state_ff, state_in;
   logic                          run_ff, run_in;
   logic [TIME_BITS-1:0]          loop_start_ff, loop_start_in;
   logic [TIME_BITS-1:0]          span_ff, span_in;
   logic                          loop_en_ff, loop_en_in;
   logic [COUNT_BITS-1:0]         count_ff, count_in;
   logic [TIME_BITS-1:0]          now_ff, now_in;
   logic [TIME_BITS-1:0]          elapsed_ff, elapsed_in;
   logic [IDX_BITS-1:0]           i_ff, i_in;
   logic [TIME_BITS-1:0]          t1_ff, t1_in;
   logic signed [LEVEL_BITS-1:0]  v1_ff, v1_in;
   logic signed [LEVEL_BITS-1:0]  v0_ff, v0_in;
   logic [TIME_BITS-1:0]          d_ff, d_in;
   logic [TIME_BITS-1:0]          len_ff, len_in;
   logic [LEVEL_BITS-1:0]         mag_ff, mag_in;
   logic                          neg_ff, neg_in;
   logic signed [SUM_BITS-1:0]    total_ff, total_in;
   logic                          big_ff, big_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   rsp_type                       rsp_data_ff, rsp_data_in;

   logic                          accept;
   logic                          wr_ok;
   logic                          fin;
   logic signed [LEVEL_BITS-1:0]  fin_level;
   logic [NW-1:0]                 count_ext;
   logic [NW-1:0]                 n_clamp;
   logic [IDX_BITS-1:0]           last_idx;
   logic [IDX_BITS-1:0]           i_next;
   logic                          seg_found;
   logic signed [LEVEL_BITS:0]    delta;
   logic [QLIM_BITS-1:0]          q_low;
   logic signed [SUM_BITS-1:0]    q_ext;
   logic signed [SUM_BITS-1:0]    v0_ext;
   logic signed [SUM_BITS-1:0]    adj;

   key_wr_type                    key_wr;
   logic [IDX_BITS-1:0]           rd_addr;
   logic [TIME_BITS-1:0]          rd_time;
   logic signed [LEVEL_BITS-1:0]  rd_level;
   md_req_type                    md_req;
   md_rsp_type                    md_rsp;

   kei_key_ram #(
      .MAX_KEYS (MAX_KEYS)
   ) u_key_ram (
      .clock    (clock),
      .reset    (reset),
      .wr       (key_wr),
      .wr_addr  (IDX_BITS'(req_data.entry_index)),
      .rd_addr  (rd_addr),
      .rd_time  (rd_time),
      .rd_level (rd_level)
   );

   kei_muldiv u_muldiv (
      .clock (clock),
      .reset (reset),
      .req   (md_req),
      .rsp   (md_rsp)
   );

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign wr_ok  = (int'(req_data.entry_index) < MAX_KEYS);

   // Clamp the keyframe count to the table and find the last slot
   assign count_ext = NW'(count_ff);
   assign n_clamp   = (count_ext < NW'(2)) ? NW'(2) :
                      ((count_ext > NW'(MAX_KEYS)) ? NW'(MAX_KEYS) : count_ext);
   assign last_idx  = IDX_BITS'(n_clamp - NW'(1));

   // Segment search: stop at the first end time at or after elapsed, or at the last segment
   assign i_next    = i_ff + IDX_BITS'(1);
   assign seg_found = (i_next == last_idx) || (rd_time >= elapsed_ff);

   // Segment level step, with start level from the read port
   assign delta = (LEVEL_BITS + 1)'(v1_ff) - (LEVEL_BITS + 1)'(rd_level);

   // Quotient and start level in the sum width
   assign q_low  = md_rsp.quo[QLIM_BITS-1:0];
   assign q_ext  = {1'b0, q_low};
   assign v0_ext = SUM_BITS'(v0_ff);

   // Round the sum toward zero
   always_comb begin
      adj = total_ff;
      if (!neg_ff && (total_ff < 0) && md_rsp.inexact) begin
         adj = total_ff + SUM_BITS'(1);
      end else if (neg_ff && (total_ff > 0) && md_rsp.inexact) begin
         adj = total_ff - SUM_BITS'(1);
      end
   end

   // Configuration writes
   always_comb begin
      loop_en_in = loop_en_ff;
      count_in   = count_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_LOOP_ENABLE: loop_en_in = csr_wdata[0];
            CSR_KEY_COUNT:   count_in   = csr_wdata[COUNT_BITS-1:0];
         endcase
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.func == FUNC_START) begin
                  state_in = ST_SPAN_LAST;
               end else if ((req_data.func == FUNC_TICK) && run_ff) begin
                  state_in = ST_END_CMP;
               end
            end
         end
         ST_SPAN_LAST:  state_in = ST_SPAN_FIRST;
         ST_SPAN_FIRST: state_in = ST_SPAN_SET;
         ST_SPAN_SET:   state_in = ST_IDLE;
         ST_END_CMP:    state_in = (elapsed_ff >= span_ff) ? ST_END_READ : ST_SRCH_READ;
         ST_END_READ:   state_in = ST_END_SET;
         ST_END_SET:    state_in = ST_IDLE;
         ST_SRCH_READ:  state_in = ST_SRCH_CHK;
         ST_SRCH_CHK:   state_in = seg_found ? ST_SEG_READ : ST_SRCH_READ;
         ST_SEG_READ:   state_in = ST_SEG_CALC;
         ST_SEG_CALC:   state_in = ST_MUL_START;
         ST_MUL_START:  state_in = (len_ff == '0) ? ST_IDLE : ST_DIV_WAIT;
         ST_DIV_WAIT:   state_in = md_rsp.done ? ST_SUM : ST_DIV_WAIT;
         ST_SUM:        state_in = ST_SAT;
         ST_SAT:        state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs and datapath updates
   always_comb begin
      run_in        = run_ff;
      loop_start_in = loop_start_ff;
      span_in       = span_ff;
      now_in        = now_ff;
      elapsed_in    = elapsed_ff;
      i_in          = i_ff;
      t1_in         = t1_ff;
      v1_in         = v1_ff;
      v0_in         = v0_ff;
      d_in          = d_ff;
      len_in        = len_ff;
      mag_in        = mag_ff;
      neg_in        = neg_ff;
      total_in      = total_ff;
      big_in        = big_ff;
      rd_addr       = i_ff;
      md_req.start  = 1'b0;
      // Operands of the multiply/divide unit
      md_req.a      = d_ff;
      md_req.b      = mag_ff;
      md_req.c      = len_ff;
      fin           = 1'b0;
      fin_level     = '0;
      key_wr.en        = 1'b0;
      key_wr.key_time  = req_data.entry_time;
      key_wr.key_level = req_data.entry_value;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               now_in     = req_data.now;
               elapsed_in = req_data.now - loop_start_ff;
               i_in       = '0;
               unique case (req_data.func)
                  FUNC_TICK: fin = !run_ff;
                  FUNC_START: ;
                  FUNC_WRITE: begin
                     key_wr.en = wr_ok;
                     run_in    = 1'b0;
                     fin       = 1'b1;
                  end
                  default: fin = 1'b1;
               endcase
            end
         end
         ST_SPAN_LAST: rd_addr = last_idx;
         ST_SPAN_FIRST: begin
            rd_addr = '0;
            t1_in   = rd_time;
         end
         ST_SPAN_SET: begin
            // Arm the run
            span_in       = t1_ff - rd_time;
            run_in        = 1'b1;
            loop_start_in = now_ff;
            fin           = 1'b1;
         end
         ST_END_CMP: ;
         ST_END_READ: rd_addr = last_idx;
         ST_END_SET: begin
            // Hold the last level, then restart or stop
            fin       = 1'b1;
            fin_level = rd_level;
            if (loop_en_ff) begin
               loop_start_in = now_ff;
            end else begin
               run_in = 1'b0;
            end
         end
         ST_SRCH_READ: rd_addr = i_next;
         ST_SRCH_CHK: begin
            if (seg_found) begin
               t1_in = rd_time;
               v1_in = rd_level;
            end else begin
               i_in = i_next;
            end
         end
         ST_SEG_READ: rd_addr = i_ff;
         ST_SEG_CALC: begin
            d_in   = elapsed_ff - rd_time;
            len_in = t1_ff - rd_time;
            v0_in  = rd_level;
            neg_in = delta[LEVEL_BITS];
            mag_in = delta[LEVEL_BITS] ? LEVEL_BITS'(-delta) : LEVEL_BITS'(delta);
         end
         ST_MUL_START: begin
            if (len_ff == '0) begin
               fin       = 1'b1;
               fin_level = v0_ff;
            end else begin
               md_req.start = 1'b1;
            end
         end
         ST_DIV_WAIT: ;
         ST_SUM: begin
            big_in   = (|md_rsp.quo[PROD_BITS-1:QLIM_BITS]) ||
                       (q_low[QLIM_BITS-1] && (|q_low[QLIM_BITS-2:0]));
            total_in = neg_ff ? (v0_ext - q_ext) : (v0_ext + q_ext);
         end
         ST_SAT: begin
            // Saturate to the level range
            fin = 1'b1;
            if (big_ff) begin
               fin_level = neg_ff ? LVL_MIN : LVL_MAX;
            end else if (adj > SUM_LMAX) begin
               fin_level = LVL_MAX;
            end else if (adj < SUM_LMIN) begin
               fin_level = LVL_MIN;
            end else begin
               fin_level = adj[LEVEL_BITS-1:0];
            end
         end
         default: ;
      endcase
   end

   // Result register
   assign rsp_valid_in       = fin;
   assign rsp_data_in.level  = fin_level;
   assign rsp_data_in.active = run_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         run_ff        <= 1'b0;
         loop_start_ff <= '0;
         span_ff       <= '0;
         loop_en_ff    <= 1'b0;
         count_ff      <= KEY_COUNT_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         run_ff        <= run_in;
         loop_start_ff <= loop_start_in;
         span_ff       <= span_in;
         loop_en_ff    <= loop_en_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff     <= now_in;
      elapsed_ff <= elapsed_in;
      i_ff       <= i_in;
      t1_ff      <= t1_in;
      v1_ff      <= v1_in;
      v0_ff      <= v0_in;
      d_ff       <= d_in;
      len_ff     <= len_in;
      mag_ff     <= mag_in;
      neg_ff     <= neg_in;
      total_ff   <= total_in;
      big_ff     <= big_in;
      if (fin) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // A write transaction stops the run and answers in the next cycle
   a_write_stops: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_data.func == FUNC_WRITE)) |=> (rsp_strobe && !rsp_data.active))
      else $error("write transaction did not stop the run");

   // A tick while stopped answers level zero in the next cycle
   a_idle_tick: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_data.func == FUNC_TICK) && !run_ff) |=>
      (rsp_strobe && (rsp_data.level == '0) && !rsp_data.active))
      else $error("idle tick result wrong");

   // A start transaction arms the run and answers after the SPAN_LAST, SPAN_FIRST and SPAN_SET states
   a_start_arms: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_data.func == FUNC_START)) |-> ##4 (rsp_strobe && rsp_data.active))
      else $error("start transaction did not arm the run");

   // No result is issued while the divider works
   a_no_strobe_in_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV_WAIT) |-> !rsp_strobe)
      else $error("result issued during divide");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import kei_pkg::*;

   localparam int PHASE_ITEMS  = 120;
   localparam int PHASE_COUNT  = 8;
   localparam int DRAIN_CYCLES = 120;
   localparam int REPORT_LIMIT = 10;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   // DUT ports; the driven inputs are known from time zero
   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      start      = 1'b0;
   logic                      busy;
   req_type                   req_data   = '0;
   logic                      rsp_strobe;
   rsp_type                   rsp_data;
   logic                      csr_we     = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index  = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata  = '0;

   // Envelope shadow state
   logic                        cfg_loop;
   logic [COUNT_BITS-1:0]       cfg_count;
   logic                        env_running;
   logic [TIME_BITS-1:0]        env_origin;
   logic [TIME_BITS-1:0]        env_span;
   logic [TIME_BITS-1:0]        key_t [DEF_MAX_KEYS];
   logic signed [LEVEL_BITS-1:0] key_v [DEF_MAX_KEYS];

   req_type     stim_q [$];
   rsp_type     level_expect_q [$];
   int unsigned send_idle_pct = 8;
   int unsigned fail_count    = 0;
   int unsigned results_checked = 0;
   int unsigned tick_count  = 0;
   int unsigned start_count = 0;
   int unsigned write_count = 0;
   int unsigned other_count = 0;

   keyframe_envelope_interpolator DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Effective number of keyframes: clamp the register to 2..16
   function automatic int unsigned keys_in_use();
      if (cfg_count < 2) begin
         return 2;
      end
      if (cfg_count > DEF_MAX_KEYS) begin
         return DEF_MAX_KEYS;
      end
      return cfg_count;
   endfunction

   // Linear interpolation inside the table, exact and truncated toward zero
   function automatic logic signed [LEVEL_BITS-1:0] interp_level(
      input logic [TIME_BITS-1:0] elapsed);
      int unsigned          n;
      int unsigned          i;
      logic [TIME_BITS-1:0] off;
      logic [TIME_BITS-1:0] seg_len;
      longint               v0;
      longint               dv;
      longint               sum;
      longint unsigned      mag;
      longint unsigned      prod;
      longint unsigned      quo;
      bit                   rem_nz;
      n = keys_in_use();
      i = 0;
      // first segment whose end is at or past elapsed, else the last one
      while (i + 2 < n && key_t[i+1] < elapsed) begin
         i++;
      end
      off     = elapsed - key_t[i];
      seg_len = key_t[i+1] - key_t[i];
      if (seg_len == '0) begin
         return key_v[i];
      end
      v0   = longint'(key_v[i]);
      dv   = longint'(key_v[i+1]) - v0;
      mag  = (dv < 0) ? -dv : dv;
      prod = {32'd0, off} * mag;
      quo  = prod / {32'd0, seg_len};
      rem_nz = (prod % {32'd0, seg_len}) != 0;
      // overshoot far past the segment saturates outright
      if (quo > (64'd1 << 34)) begin
         return (dv < 0) ? LVL_MIN : LVL_MAX;
      end
      sum = (dv >= 0) ? v0 + longint'(quo) : v0 - longint'(quo);
      if (dv >= 0 && sum < 0 && rem_nz) begin
         sum++;
      end
      if (dv < 0 && sum > 0 && rem_nz) begin
         sum--;
      end
      if (sum > longint'(LVL_MAX)) begin
         sum = longint'(LVL_MAX);
      end
      if (sum < longint'(LVL_MIN)) begin
         sum = longint'(LVL_MIN);
      end
      return LEVEL_BITS'(sum);
   endfunction

   // Advance the shadow envelope by one transaction and return its result
   function automatic rsp_type envelope_step(input req_type r);
      rsp_type              res;
      logic [TIME_BITS-1:0] el;
      int unsigned          n;
      n         = keys_in_use();
      res.level = '0;
      case (r.func)
         FUNC_TICK: begin
            if (env_running) begin
               el = r.now - env_origin;
               if (el >= env_span) begin
                  res.level = key_v[n-1];
                  if (cfg_loop) begin
                     env_origin = r.now;
                  end else begin
                     env_running = 1'b0;
                  end
               end else begin
                  res.level = interp_level(el);
               end
            end
         end
         FUNC_START: begin
            env_running = 1'b1;
            env_origin  = r.now;
            env_span    = key_t[n-1] - key_t[0];
         end
         FUNC_WRITE: begin
            key_t[r.entry_index] = r.entry_time;
            key_v[r.entry_index] = r.entry_value;
            env_running = 1'b0;
         end
         default: begin
         end
      endcase
      res.active = env_running;
      return res;
   endfunction

   function automatic req_type make_item(input logic [1:0] f,
                                         input logic [TIME_BITS-1:0] now,
                                         input logic [ENTRY_IDX_BITS-1:0] idx,
                                         input logic [TIME_BITS-1:0] t,
                                         input logic [LEVEL_BITS-1:0] v);
      req_type r;
      r.func        = f;
      r.now         = now;
      r.entry_index = idx;
      r.entry_time  = t;
      r.entry_value = v;
      return r;
   endfunction

   function automatic logic [LEVEL_BITS-1:0] rand_level();
      case ($urandom_range(7))
         0:       return LVL_MAX;
         1:       return LVL_MIN;
         2:       return '0;
         default: return LEVEL_BITS'($urandom);
      endcase
   endfunction

   task automatic note_failure(input string msg);
      if (fail_count < REPORT_LIMIT) begin
         $display("[%0t] mismatch: %s", $realtime, msg);
      end
      fail_count++;
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [CSR_DATA_BITS-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      if (idx == CSR_LOOP_ENABLE) begin
         cfg_loop = val[0];
      end else begin
         cfg_count = val;
      end
   endtask

   // Hold until every queued transaction is accepted and answered
   task automatic wait_idle();
      while (stim_q.size() != 0 || level_expect_q.size() != 0 || start || busy) begin
         @(posedge clock);
      end
   endtask

   // Queue one phase of random envelope traffic
   task automatic queue_phase(input int budget);
      int unsigned          n;
      int unsigned          i;
      int unsigned          nt;
      int                   queued;
      logic [TIME_BITS-1:0] t_cur;
      logic [TIME_BITS-1:0] t_first;
      logic [TIME_BITS-1:0] span;
      logic [TIME_BITS-1:0] now_cur;
      logic [TIME_BITS-1:0] step_max;
      queued = 0;
      n = keys_in_use();
      while (queued < budget) begin
         case ($urandom_range(9))
            7: begin
               // noise: any function code, any field content
               for (i = 0; i < 6; i++) begin
                  stim_q.push_back(make_item(2'($urandom), $urandom, 4'($urandom),
                                             $urandom, 16'($urandom)));
               end
               queued += 6;
            end
            8: begin
               // unordered table with wide times, then arm and tick anywhere
               nt = $urandom_range(1, n);
               for (i = 0; i < nt; i++) begin
                  stim_q.push_back(make_item(FUNC_WRITE, $urandom, 4'($urandom_range(n - 1)),
                                             $urandom, rand_level()));
               end
               stim_q.push_back(make_item(FUNC_START, $urandom, 4'($urandom), $urandom,
                                          16'($urandom)));
               for (i = 0; i < 5; i++) begin
                  stim_q.push_back(make_item(FUNC_TICK, $urandom, 4'($urandom), $urandom,
                                             16'($urandom)));
               end
               queued += nt + 6;
            end
            9: begin
               // re-arm on the current table, tick with wild jumps, drop in an unused code
               now_cur = $urandom;
               stim_q.push_back(make_item(FUNC_START, now_cur, 4'($urandom), $urandom,
                                          16'($urandom)));
               for (i = 0; i < 6; i++) begin
                  now_cur += ($urandom_range(1) == 0) ? $urandom : $urandom_range(600);
                  stim_q.push_back(make_item((i == 3) ? FUNC_UNUSED : FUNC_TICK, now_cur,
                                             4'($urandom), $urandom, 16'($urandom)));
               end
               queued += 7;
            end
            default: begin
               // well-formed run: ordered table, arm, walk time forward
               step_max = ($urandom_range(4) == 0) ? 32'h0FFF_FFFF : 32'd300;
               t_cur    = ($urandom_range(3) == 0) ? $urandom_range(50) : 0;
               t_first  = t_cur;
               for (i = 0; i < n; i++) begin
                  if (i > 0 && $urandom_range(7) != 0) begin
                     t_cur += $urandom_range(step_max);
                  end
                  // leave a slot untouched now and then
                  if ($urandom_range(9) != 0) begin
                     stim_q.push_back(make_item(FUNC_WRITE, $urandom, 4'(i), t_cur,
                                                rand_level()));
                     queued++;
                  end
               end
               span    = t_cur - t_first;
               now_cur = $urandom;
               stim_q.push_back(make_item(FUNC_START, now_cur, 4'($urandom), $urandom,
                                          16'($urandom)));
               nt = $urandom_range(4, 14);
               for (i = 0; i < nt; i++) begin
                  case ($urandom_range(9))
                     0:       now_cur += span;
                     1:       now_cur += 1;
                     2:       now_cur -= $urandom_range(20);
                     default: now_cur += $urandom_range(span / 3 + 1);
                  endcase
                  stim_q.push_back(make_item(FUNC_TICK, now_cur, 4'($urandom), $urandom,
                                             16'($urandom)));
               end
               queued += nt + 1;
            end
         endcase
      end
   endtask

   // Driver: present queued transactions, hold while busy, idle at random
   always @(posedge clock) begin
      if (reset) begin
         start    <= 1'b0;
         req_data <= '0;
      end else begin
         if (start && !busy) begin
            level_expect_q.push_back(envelope_step(req_data));
            case (req_data.func)
               FUNC_TICK:  tick_count++;
               FUNC_START: start_count++;
               FUNC_WRITE: write_count++;
               default:    other_count++;
            endcase
            void'(stim_q.pop_front());
         end
         if (!start || !busy) begin
            if (stim_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               start    <= 1'b1;
               req_data <= stim_q[0];
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each strobed result against the oldest expected level
   always @(posedge clock) begin : result_monitor
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (level_expect_q.size() == 0) begin
            note_failure($sformatf("unexpected result level %0d active %0b",
                                   rsp_data.level, rsp_data.active));
         end else begin
            want = level_expect_q.pop_front();
            results_checked++;
            if (rsp_data.level !== want.level || rsp_data.active !== want.active) begin
               note_failure($sformatf("level exp %0d got %0d, active exp %0b got %0b",
                                      want.level, rsp_data.level, want.active,
                                      rsp_data.active));
            end
         end
      end
   end

   // Stimulus: reset, directed checks, then register phases of random traffic
   initial begin : stimulus
      int unsigned           ph;
      logic                  loop_sel;
      logic [COUNT_BITS-1:0] count_sel;
      cfg_loop    = 1'b0;
      cfg_count   = KEY_COUNT_RESET;
      env_running = 1'b0;
      env_origin  = '0;
      env_span    = '0;
      for (int k = 0; k < DEF_MAX_KEYS; k++) begin
         key_t[k] = '0;
         key_v[k] = '0;
      end
      key_t[1] = KEY1_TIME_RESET;
      key_t[2] = KEY2_TIME_RESET;
      key_v[1] = KEY1_LEVEL_RESET;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // idle tick and unused code
      stim_q.push_back(make_item(FUNC_TICK, 32'd0, 4'd0, 32'd0, 16'd0));
      stim_q.push_back(make_item(FUNC_UNUSED, 32'hFFFF_FFFF, 4'hF, 32'hFFFF_FFFF, 16'hFFFF));
      // default table, armed just below the timestamp wrap
      stim_q.push_back(make_item(FUNC_START, 32'hFFFF_FF00, 4'd0, 32'd0, 16'd0));
      stim_q.push_back(make_item(FUNC_TICK, 32'hFFFF_FF00 + 32'd250, 4'd0, 32'd0, 16'd0));
      stim_q.push_back(make_item(FUNC_TICK, 32'hFFFF_FF00 + 32'd500, 4'd0, 32'd0, 16'd0));
      stim_q.push_back(make_item(FUNC_TICK, 32'hFFFF_FF00 + 32'd750, 4'd0, 32'd0, 16'd0));
      stim_q.push_back(make_item(FUNC_TICK, 32'hFFFF_FF00 + 32'd1000, 4'd0, 32'd0, 16'd0));
      stim_q.push_back(make_item(FUNC_TICK, 32'd2000, 4'd0, 32'd0, 16'd0));
      // full-scale swing: rounding toward zero near the midpoint, then end of span
      stim_q.push_back(make_item(FUNC_WRITE, 32'd0, 4'd0, 32'd0, LVL_MIN));
      stim_q.push_back(make_item(FUNC_WRITE, 32'd0, 4'd1, 32'd10, LVL_MAX));
      stim_q.push_back(make_item(FUNC_WRITE, 32'd0, 4'd2, 32'd10, 16'd0));
      stim_q.push_back(make_item(FUNC_START, 32'd0, 4'd0, 32'd0, 16'd0));
      stim_q.push_back(make_item(FUNC_TICK, 32'd5, 4'd0, 32'd0, 16'd0));
      stim_q.push_back(make_item(FUNC_TICK, 32'd10, 4'd0, 32'd0, 16'd0));
      // zero-length first segment, last key at the top of the time range
      stim_q.push_back(make_item(FUNC_WRITE, 32'd0, 4'd0, 32'd3, 16'd1000));
      stim_q.push_back(make_item(FUNC_WRITE, 32'd0, 4'd1, 32'd3, -16'sd1000));
      stim_q.push_back(make_item(FUNC_WRITE, 32'd0, 4'd2, 32'hFFFF_FFFF, LVL_MIN));
      stim_q.push_back(make_item(FUNC_START, 32'd0, 4'd0, 32'd0, 16'd0));
      stim_q.push_back(make_item(FUNC_TICK, 32'd1, 4'd0, 32'd0, 16'd0));
      stim_q.push_back(make_item(FUNC_TICK, 32'h8000_0000, 4'd0, 32'd0, 16'd0));
      // elapsed before the first key: wrapped offset overshoots and saturates
      stim_q.push_back(make_item(FUNC_WRITE, 32'd0, 4'd0, 32'd100, 16'd0));
      stim_q.push_back(make_item(FUNC_WRITE, 32'd0, 4'd1, 32'd110, 16'd30000));
      stim_q.push_back(make_item(FUNC_START, 32'd0, 4'd0, 32'd0, 16'd0));
      stim_q.push_back(make_item(FUNC_TICK, 32'd50, 4'd0, 32'd0, 16'd0));
      // top slot, extreme fields
      stim_q.push_back(make_item(FUNC_WRITE, 32'd0, 4'hF, 32'hFFFF_FFFF, LVL_MAX));
      wait_idle();

      for (ph = 0; ph < PHASE_COUNT; ph++) begin
         case (ph)
            0:       begin loop_sel = 1'b1; count_sel = 5'd2;  end
            1:       begin loop_sel = 1'b0; count_sel = 5'd16; end
            2:       begin loop_sel = 1'b1; count_sel = 5'd0;  end
            3:       begin loop_sel = 1'b0; count_sel = 5'd31; end
            4:       begin loop_sel = 1'b1; count_sel = 5'($urandom_range(3, 15)); end
            5:       begin loop_sel = 1'b0; count_sel = 5'd1;  end
            6:       begin loop_sel = 1'b1; count_sel = 5'd16; end
            default: begin
               loop_sel  = 1'($urandom);
               count_sel = 5'($urandom_range(17, 30));
            end
         endcase
         send_idle_pct = (ph < 3) ? 8 : (ph < 6) ? 70 : 0;
         csr_write(CSR_LOOP_ENABLE, {4'($urandom), loop_sel});
         csr_write(CSR_KEY_COUNT, count_sel);
         queue_phase(PHASE_ITEMS);
         wait_idle();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (level_expect_q.size() != 0) begin
         note_failure($sformatf("%0d results never arrived", level_expect_q.size()));
      end
      $display("covered %0d transactions: %0d ticks, %0d starts, %0d table writes, %0d unused",
               tick_count + start_count + write_count + other_count, tick_count, start_count,
               write_count, other_count);
      $display("%0d results checked over %0d register settings, %0d mismatches",
               results_checked, PHASE_COUNT + 1, fail_count);
      if (fail_count == 0) begin
         $display("keyframe_envelope_interpolator regression: pass");
      end else begin
         $display("keyframe_envelope_interpolator regression: fail");
      end
      $finish;
   end

   // Watchdog: end a hung run
   initial begin
      #8_000_000;
      $display("keyframe_envelope_interpolator regression: fail");
      $finish;
   end

endmodule

FILE: sim.f
hdl/kei_pkg.sv
hdl/kei_key_ram.sv
hdl/kei_muldiv.sv
hdl/keyframe_envelope_interpolator.sv
tb/tb_top.sv
